### rtl/blmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package blmc_pkg;

   localparam int BTN_COUNT = 4;
   localparam int BTN_IDX_W = 2;

   typedef logic [3:0] lmode_type;

   localparam lmode_type MODE_OFF        = 4'd0;
   localparam lmode_type MODE_ON         = 4'd1;
   localparam lmode_type MODE_FLASH      = 4'd2;
   localparam lmode_type MODE_TOG_ON     = 4'd3;
   localparam lmode_type MODE_TOG_OFF    = 4'd4;
   localparam lmode_type MODE_FLASH_TILL = 4'd5;
   localparam lmode_type MODE_ON_TILL    = 4'd6;
   localparam lmode_type MODE_OFF_TILL   = 4'd7;
   localparam lmode_type MODE_ON_WHILE   = 4'd8;
   localparam lmode_type MODE_OFF_WHILE  = 4'd9;

   typedef enum logic [1:0] {
      KIND_POLL      = 2'd0,
      KIND_BLINK     = 2'd1,
      KIND_SET_MODE  = 2'd2,
      KIND_SET_LAMPS = 2'd3
   } kind_type;

   localparam logic RSP_LAMPS = 1'b0;
   localparam logic RSP_EVENT = 1'b1;

   typedef struct packed {
      lmode_type [BTN_COUNT-1:0] modes;
      logic [BTN_COUNT-1:0]      pressed;
      logic [BTN_COUNT-1:0]      lamps;
      logic                      phase;
   } state_type;

   // one pending run of results: lamp word first, then one event per set bit
   typedef struct packed {
      logic                      lamp;
      logic [BTN_COUNT-1:0]      events;
      logic [BTN_COUNT-1:0]      status;
      logic [BTN_COUNT-1:0]      lights;
      lmode_type [BTN_COUNT-1:0] modes;
      logic [31:0]               stamp;
   } run_type;

endpackage

`default_nettype wire

### rtl/blmc_update.sv
`timescale 1ns / 1ps
`default_nettype none

module blmc_update (
   input  wire blmc_pkg::kind_type  kind,
   input  wire logic [3:0]          status,
   input  wire logic [1:0]          index,
   input  wire logic [3:0]          new_mode,
   input  wire logic [3:0]          new_lights,
   input  wire logic [31:0]         stamp,
   input  wire blmc_pkg::state_type cur,
   output blmc_pkg::state_type      next,
   output blmc_pkg::run_type        run,
   output logic                     emit
);
   import blmc_pkg::*;

   logic [BTN_COUNT-1:0] status_m;
   logic [BTN_COUNT-1:0] changed;
   logic [BTN_COUNT-1:0] flip;
   lmode_type [BTN_COUNT-1:0] poll_modes;

   assign status_m = status[BTN_COUNT-1:0];
   assign changed  = status_m ^ cur.pressed;

   always_comb begin
      for (int i = 0; i < BTN_COUNT; i++) begin
         poll_modes[i] = cur.modes[i];
         flip[i]       = 1'b0;
         if (changed[i]) begin
            if (status_m[i]) begin
               case (cur.modes[i])
                  MODE_FLASH_TILL: begin
                     poll_modes[i] = MODE_OFF;
                     flip[i]       = cur.lamps[i];
                  end
                  MODE_ON_TILL: begin
                     poll_modes[i] = MODE_OFF;
                     flip[i]       = 1'b1;
                  end
                  MODE_OFF_TILL: begin
                     poll_modes[i] = MODE_ON;
                     flip[i]       = 1'b1;
                  end
                  MODE_TOG_ON: begin
                     poll_modes[i] = MODE_TOG_OFF;
                     flip[i]       = 1'b1;
                  end
                  MODE_TOG_OFF: begin
                     poll_modes[i] = MODE_TOG_ON;
                     flip[i]       = 1'b1;
                  end
                  MODE_ON_WHILE, MODE_OFF_WHILE: begin
                     flip[i] = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end else if (cur.modes[i] == MODE_ON_WHILE || cur.modes[i] == MODE_OFF_WHILE) begin
               flip[i] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      next = cur;
      emit = 1'b0;
      case (kind)
         KIND_POLL: begin
            if (changed != '0) begin
               next.modes   = poll_modes;
               next.lamps   = cur.lamps ^ flip;
               next.pressed = status_m;
               emit         = 1'b1;
            end
         end
         KIND_BLINK: begin
            next.phase = ~cur.phase;
            for (int i = 0; i < BTN_COUNT; i++) begin
               if (cur.modes[i] == MODE_FLASH || cur.modes[i] == MODE_FLASH_TILL) begin
                  next.lamps[i] = cur.phase;
               end
            end
            emit = 1'b1;
         end
         KIND_SET_MODE: begin
            if (int'(index) < BTN_COUNT && new_mode <= MODE_OFF_WHILE) begin
               next.modes[index[BTN_IDX_W-1:0]] = new_mode;
            end
         end
         KIND_SET_LAMPS: begin
            next.lamps = new_lights[BTN_COUNT-1:0];
            emit       = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      run.lamp   = 1'b1;
      run.events = (kind == KIND_POLL) ? changed : '0;
      run.status = status_m;
      run.lights = next.lamps;
      run.modes  = next.modes;
      run.stamp  = stamp;
   end

endmodule

`default_nettype wire

### rtl/button_light_mode_controller_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake            payload
// req      in   req_tvalid/tready    tdata: status, index, new_mode, new_lights, stamp
//                                    tuser: item kind
// rsp      out  rsp_tvalid/tready    tdata: lights, number, pressed, mode, time
//                                    tuser: result kind, tlast: end of run
//
// An item updates the button state in the cycle it is accepted; its results
// leave one per cycle while rsp is ready, from a run register through the
// output register. A poll with n changed buttons gives n+1 results, a blink
// tick or lamp write one result, a mode write or unchanged poll none. The
// next item is taken as the current run hands over its last result.
// Synchronous reset sets all modes to toggle off and clears lamps and presses.
// A stalled rsp holds its result and stops the run; req stalls once the run is full.

module button_light_mode_controller_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [3:0] button_status, [5:4] button_index, [9:6] new_mode,
   // [13:10] new_lights, [45:14] time_stamp, [47:46] zero
   input  wire logic [47:0] req_tdata,
   // [1:0] item kind
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [3:0] lights, [5:4] button_number, [6] pressed, [10:7] button_mode,
   // [42:11] event_time, [47:43] zero
   output logic [47:0]      rsp_tdata,
   // [0] result_kind
   output logic             rsp_tuser,
   output logic             rsp_tlast
);
   import blmc_pkg::*;

   state_type state_ff, state_in;
   run_type   run_ff, run_in, run_new;
   logic      run_valid_ff, run_valid_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;
   logic      rsp_kind_ff, rsp_kind_in;
   logic      rsp_last_ff, rsp_last_in;

   logic      emit;
   logic      req_fire;
   logic      out_load;
   logic      run_final;
   logic [BTN_IDX_W-1:0] pick;
   logic [BTN_COUNT-1:0] events_left;

   blmc_update u_update (
      .kind       (kind_type'(req_tuser)),
      .status     (req_tdata[3:0]),
      .index      (req_tdata[5:4]),
      .new_mode   (req_tdata[9:6]),
      .new_lights (req_tdata[13:10]),
      .stamp      (req_tdata[45:14]),
      .cur        (state_ff),
      .next       (state_in),
      .run        (run_new),
      .emit       (emit)
   );

   assign out_load = !rsp_valid_ff || rsp_tready;

   always_comb begin
      pick = '0;
      for (int i = BTN_COUNT - 1; i >= 0; i--) begin
         if (run_ff.events[i]) begin
            pick = BTN_IDX_W'(i);
         end
      end
   end

   always_comb begin
      events_left = run_ff.events;
      if (!run_ff.lamp) begin
         events_left[pick] = 1'b0;
      end
   end

   assign run_final  = (events_left == '0);
   assign req_tready = !run_valid_ff || (run_final && out_load);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      run_in       = run_ff;
      run_valid_in = run_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = run_valid_ff;
         rsp_last_in  = run_final;
         if (run_ff.lamp) begin
            rsp_kind_in = RSP_LAMPS;
            rsp_data_in = {44'd0, run_ff.lights};
         end else begin
            rsp_kind_in = RSP_EVENT;
            rsp_data_in = {5'd0, run_ff.stamp, run_ff.modes[pick], run_ff.status[pick],
                           pick, run_ff.lights};
         end
         if (run_valid_ff) begin
            run_in.lamp   = 1'b0;
            run_in.events = events_left;
            if (run_final) begin
               run_valid_in = 1'b0;
            end
         end
      end
      if (req_fire && emit) begin
         run_in       = run_new;
         run_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.modes   <= {BTN_COUNT{MODE_TOG_OFF}};
         state_ff.pressed <= '0;
         state_ff.lamps   <= '0;
         state_ff.phase   <= 1'b0;
         run_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (req_fire) begin
            state_ff <= state_in;
         end
         run_valid_ff <= run_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff      <= run_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import blmc_pkg::*;

   localparam int STALL_LIMIT = 1000;
   localparam int RANDOM_ITEMS = 130;
   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  status;
      logic [1:0]  index;
      lmode_type   nmode;
      logic [3:0]  nlights;
      logic [31:0] stamp;
   } req_item_t;

   typedef struct packed {
      logic        kind;
      logic [3:0]  lights;
      logic [1:0]  number;
      logic        pressed;
      lmode_type   mode;
      logic [31:0] etime;
      logic        last;
   } report_t;

   typedef struct packed {
      req_item_t  item;
      bit         typed;
      logic [3:0] lamps;
   } dir_row_t;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   // predicted block state
   lmode_type   btn_mode [BTN_COUNT];
   logic [3:0]  btn_down;
   logic [3:0]  lamp_word;
   logic        blink_on;
   logic [31:0] btn_stamp [BTN_COUNT];

   report_t     new_reports [$];
   report_t     due_reports [$];
   report_t     seen_rsp;
   report_t     want_rsp;
   int          mismatch_count = 0;
   bit          steady = 1'b0;
   bit          hold_burst = 1'b0;

   // typed rows carry their expected lamp word; the predictor's reports are used for the rest
   dir_row_t directed_rows [0:24] = '{
      '{'{KIND_BLINK,     4'h0, 2'd0, MODE_OFF,        4'h0, 32'h0},         1'b1, 4'h0},
      '{'{KIND_SET_LAMPS, 4'h0, 2'd0, MODE_OFF,        4'hF, 32'h0},         1'b1, 4'hF},
      '{'{KIND_SET_LAMPS, 4'h0, 2'd0, MODE_OFF,        4'h0, 32'h0},         1'b1, 4'h0},
      '{'{KIND_POLL,      4'h0, 2'd0, MODE_OFF,        4'h0, 32'h1},         1'b0, 4'h0},
      '{'{KIND_SET_MODE,  4'h0, 2'd0, MODE_FLASH_TILL, 4'h0, 32'h0},         1'b0, 4'h0},
      '{'{KIND_SET_MODE,  4'h0, 2'd1, MODE_ON_TILL,    4'h0, 32'h0},         1'b0, 4'h0},
      '{'{KIND_SET_MODE,  4'h0, 2'd2, MODE_OFF_TILL,   4'h0, 32'h0},         1'b0, 4'h0},
      '{'{KIND_SET_MODE,  4'h0, 2'd3, MODE_ON_WHILE,   4'h0, 32'h0},         1'b0, 4'h0},
      '{'{KIND_SET_LAMPS, 4'h0, 2'd0, MODE_OFF,        4'hA, 32'h0},         1'b1, 4'hA},
      '{'{KIND_POLL,      4'hF, 2'd0, MODE_OFF,        4'h0, 32'hFFFF_FFFF}, 1'b0, 4'h0},
      '{'{KIND_POLL,      4'h0, 2'd0, MODE_OFF,        4'h0, 32'h0},         1'b0, 4'h0},
      '{'{KIND_SET_MODE,  4'h0, 2'd0, MODE_OFF_WHILE,  4'h0, 32'h0},         1'b0, 4'h0},
      '{'{KIND_SET_MODE,  4'h0, 2'd1, MODE_FLASH,      4'h0, 32'h0},         1'b0, 4'h0},
      '{'{KIND_SET_MODE,  4'h0, 2'd2, MODE_OFF,        4'h0, 32'h0},         1'b0, 4'h0},
      '{'{KIND_SET_MODE,  4'h0, 2'd3, MODE_ON,         4'h0, 32'h0},         1'b0, 4'h0},
      '{'{KIND_SET_MODE,  4'h0, 2'd3, 4'hF,            4'h0, 32'h0},         1'b0, 4'h0},
      '{'{KIND_SET_MODE,  4'h0, 2'd2, 4'hA,            4'h0, 32'h0},         1'b0, 4'h0},
      '{'{KIND_BLINK,     4'h0, 2'd0, MODE_OFF,        4'h0, 32'h0},         1'b0, 4'h0},
      '{'{KIND_BLINK,     4'h0, 2'd0, MODE_OFF,        4'h0, 32'h0},         1'b0, 4'h0},
      '{'{KIND_POLL,      4'h5, 2'd0, MODE_OFF,        4'h0, 32'h0001_2345}, 1'b0, 4'h0},
      '{'{KIND_POLL,      4'hA, 2'd0, MODE_OFF,        4'h0, 32'h8000_0000}, 1'b0, 4'h0},
      '{'{KIND_SET_MODE,  4'h0, 2'd1, MODE_TOG_ON,     4'h0, 32'h0},         1'b0, 4'h0},
      '{'{KIND_SET_MODE,  4'h0, 2'd0, MODE_TOG_OFF,    4'h0, 32'h0},         1'b0, 4'h0},
      '{'{KIND_POLL,      4'h0, 2'd0, MODE_OFF,        4'h0, 32'h7FFF_FFFF}, 1'b0, 4'h0},
      '{'{KIND_SET_LAMPS, 4'h0, 2'd0, MODE_OFF,        4'h5, 32'h0},         1'b1, 4'h5}
   };

   button_light_mode_controller_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic predict_reports(input req_item_t it, output bit ignored);
      logic [3:0] changed;
      logic [3:0] lamps;
      lmode_type  m;
      bit         flip;
      report_t    r;
      ignored = 1'b0;
      new_reports.delete();
      r = '0;
      r.kind = RSP_LAMPS;
      case (it.kind)
         KIND_POLL: begin
            changed = it.status ^ btn_down;
            if (changed == '0) begin
               ignored = 1'b1;
            end else begin
               lamps = lamp_word;
               for (int i = 0; i < BTN_COUNT; i++) begin
                  if (changed[i]) begin
                     m = btn_mode[i];
                     flip = 1'b0;
                     btn_stamp[i] = it.stamp;
                     if (it.status[i]) begin
                        case (m)
                           MODE_FLASH_TILL: begin
                              m = MODE_OFF;
                              flip = lamp_word[i];
                           end
                           MODE_ON_TILL: begin
                              m = MODE_OFF;
                              flip = 1'b1;
                           end
                           MODE_OFF_TILL: begin
                              m = MODE_ON;
                              flip = 1'b1;
                           end
                           MODE_TOG_ON: begin
                              m = MODE_TOG_OFF;
                              flip = 1'b1;
                           end
                           MODE_TOG_OFF: begin
                              m = MODE_TOG_ON;
                              flip = 1'b1;
                           end
                           MODE_ON_WHILE, MODE_OFF_WHILE: flip = 1'b1;
                           default: flip = 1'b0;
                        endcase
                     end else begin
                        flip = (m == MODE_ON_WHILE) || (m == MODE_OFF_WHILE);
                     end
                     btn_mode[i] = m;
                     lamps[i] = lamps[i] ^ flip;
                  end
               end
               lamp_word = lamps;
               r.lights = lamps;
               new_reports.push_back(r);
               for (int i = 0; i < BTN_COUNT; i++) begin
                  if (changed[i]) begin
                     r.kind = RSP_EVENT;
                     r.number = 2'(i);
                     r.pressed = it.status[i];
                     r.mode = btn_mode[i];
                     r.etime = btn_stamp[i];
                     new_reports.push_back(r);
                  end
               end
               btn_down = it.status;
            end
         end
         KIND_BLINK: begin
            blink_on = ~blink_on;
            for (int i = 0; i < BTN_COUNT; i++) begin
               if (btn_mode[i] == MODE_FLASH || btn_mode[i] == MODE_FLASH_TILL) begin
                  lamp_word[i] = ~blink_on;
               end
            end
            r.lights = lamp_word;
            new_reports.push_back(r);
         end
         KIND_SET_MODE: begin
            if (it.nmode <= MODE_OFF_WHILE) begin
               btn_mode[it.index] = it.nmode;
            end else begin
               ignored = 1'b1;
            end
         end
         default: begin
            lamp_word = it.nlights;
            r.lights = lamp_word;
            new_reports.push_back(r);
         end
      endcase
      if (new_reports.size() > 0) begin
         new_reports[new_reports.size() - 1].last = 1'b1;
      end
   endtask

   task automatic drive_item(input req_item_t it, input bit typed, input logic [3:0] lamps,
                             output bit ignored);
      report_t r;
      req_tdata <= {2'b00, it.stamp, it.nlights, it.nmode, it.index, it.status};
      req_tuser <= it.kind;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_reports(it, ignored);
      if (typed) begin
         new_reports.delete();
         r = '0;
         r.kind = RSP_LAMPS;
         r.lights = lamps;
         r.last = 1'b1;
         new_reports.push_back(r);
      end
      foreach (new_reports[k]) due_reports.push_back(new_reports[k]);
      if (!steady && !hold_burst && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   function automatic req_item_t pick_item();
      req_item_t it;
      int        roll;
      int        sub;
      it.status = 4'($urandom_range(15));
      it.index = 2'($urandom_range(3));
      it.nmode = ($urandom_range(99) < 85) ? 4'($urandom_range(9)) : 4'($urandom_range(15, 10));
      it.nlights = 4'($urandom_range(15));
      it.stamp = $urandom;
      roll = $urandom_range(99);
      if (roll < 45) begin
         it.kind = KIND_POLL;
         sub = $urandom_range(99);
         if (sub < 15) begin
            it.status = btn_down;
         end else if (sub < 40) begin
            it.status = btn_down ^ (4'b0001 << $urandom_range(3));
         end
      end else if (roll < 60) begin
         it.kind = KIND_BLINK;
      end else if (roll < 85) begin
         it.kind = KIND_SET_MODE;
      end else begin
         it.kind = KIND_SET_LAMPS;
      end
      return it;
   endfunction

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
   endtask

   initial begin
      int  n;
      int  useful;
      bit  ignored;
      for (int i = 0; i < BTN_COUNT; i++) begin
         btn_mode[i] = MODE_TOG_OFF;
         btn_stamp[i] = '0;
      end
      btn_down = '0;
      lamp_word = '0;
      blink_on = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) begin
         drive_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].lamps,
                    ignored);
      end
      wait_drained();
      n = 0;
      useful = 0;
      while (useful < RANDOM_ITEMS) begin
         if (n == 40) hold_burst <= 1'b1;
         if (n == 90) wait_drained();
         steady <= (n >= 100) && (n < 140);
         drive_item(pick_item(), 1'b0, 4'h0, ignored);
         if (!ignored) useful++;
         n++;
      end
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // result side: random back-pressure, one long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (hold_burst) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_burst <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 23);
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_rsp.kind = rsp_tuser;
         seen_rsp.lights = rsp_tdata[3:0];
         seen_rsp.number = rsp_tdata[5:4];
         seen_rsp.pressed = rsp_tdata[6];
         seen_rsp.mode = rsp_tdata[10:7];
         seen_rsp.etime = rsp_tdata[42:11];
         seen_rsp.last = rsp_tlast;
         if (due_reports.size() == 0) begin
            $display("%0t ns: unexpected transaction, expected none, actual %0h",
                     $time, seen_rsp);
            mismatch_count++;
         end else begin
            want_rsp = due_reports.pop_front();
            check_field("result_kind", 32'(want_rsp.kind), 32'(seen_rsp.kind));
            check_field("lights", 32'(want_rsp.lights), 32'(seen_rsp.lights));
            check_field("button_number", 32'(want_rsp.number), 32'(seen_rsp.number));
            check_field("pressed", 32'(want_rsp.pressed), 32'(seen_rsp.pressed));
            check_field("button_mode", 32'(want_rsp.mode), 32'(seen_rsp.mode));
            check_field("event_time", want_rsp.etime, seen_rsp.etime);
            check_field("last", 32'(want_rsp.last), 32'(seen_rsp.last));
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("tb_top failed");
      $finish;
   end

endmodule
